>>> hdl/mtf_pkg.sv
package mtf_pkg;

   localparam int DATA_W        = 32;
   localparam int ENTRY_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_FIND   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH,
      ACT_POP,
      ACT_FIND,
      ACT_REMOVE
   } act_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic                      found;
      logic signed [DATA_W-1:0] popped_value;
      logic [ENTRY_W-1:0]        entry_count;
   } rsp_type;

   typedef struct packed {
      logic    compare;
      logic    scan;
      logic    apply;
      act_type act;
   } cell_ctl_type;

endpackage

>>> hdl/mtf_cell.sv
module mtf_cell (
   input  logic                              clock,
   input  mtf_pkg::cell_ctl_type             ctl,
   input  logic                              valid,
   input  logic signed [mtf_pkg::DATA_W-1:0] key,
   input  logic signed [mtf_pkg::DATA_W-1:0] front_data,
   input  logic signed [mtf_pkg::DATA_W-1:0] rear_data,
   input  logic                              chain_prev,
   output logic signed [mtf_pkg::DATA_W-1:0] data,
   output logic                              chain_out
);
   import mtf_pkg::*;

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     hit_ff, hit_in;
   logic                     ahead_ff, ahead_in;

   always_comb begin
      hit_in   = hit_ff;
      ahead_in = ahead_ff;
      data_in  = data_ff;
      if (ctl.compare) begin
         hit_in   = valid && (data_ff == key);
         ahead_in = 1'b0;
      end
      if (ctl.scan) begin
         ahead_in = chain_prev;
      end
      if (ctl.apply) begin
         case (ctl.act)
            ACT_PUSH: begin
               data_in = front_data;
            end
            ACT_POP: begin
               data_in = rear_data;
            end
            ACT_FIND: begin
               if (!ahead_ff) begin
                  data_in = front_data;
               end
            end
            ACT_REMOVE: begin
               if (ahead_ff || hit_ff) begin
                  data_in = rear_data;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      hit_ff   <= hit_in;
      ahead_ff <= ahead_in;
   end

   assign data      = data_ff;
   assign chain_out = ahead_ff || hit_ff;

endmodule

>>> hdl/move_to_front_list_core.sv
// Channel   Handshake             Payload             Direction
// request   start / busy          req_word (req_type) in
// response  rsp_strobe            rsp_word (rsp_type) out
//
// Push and pop go from accept straight to the list update state, which registers the strobe.
// Find and remove pass first through a compare state, in which every cell compares at once,
// then a scan state while the earlier-hit flag ripples down the cell row, then the update.
// One operation at a time; busy stays high through the list update cycle.
// Synchronous reset empties the list; entry values are not cleared.
// The response strobe lasts one cycle and cannot be held off.
module move_to_front_list_core #(
   parameter int DEPTH = mtf_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mtf_pkg::req_type req_word,
   output logic             rsp_strobe,
   output mtf_pkg::rsp_type rsp_word
);
   import mtf_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPARE = 4'b0010,
      ST_SCAN    = 4'b0100,
      ST_APPLY   = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [SW-1:0]            scan_ff, scan_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] data_w  [DEPTH];
   logic                     chain_w [DEPTH];
   logic                     accept;
   logic                     empty;
   logic                     full;
   logic                     found;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(DEPTH));
   assign found  = chain_w[DEPTH-1];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [DATA_W-1:0] front_d;
         logic signed [DATA_W-1:0] rear_d;
         logic                     prev_c;
         if (gi == 0) begin : g_head
            assign front_d = value_ff;
            assign prev_c  = 1'b0;
         end else begin : g_body
            assign front_d = data_w[gi-1];
            assign prev_c  = chain_w[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign rear_d = data_w[gi];
         end else begin : g_inner
            assign rear_d = data_w[gi+1];
         end
         mtf_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .valid      (count_ff > CW'(gi)),
            .key        (value_ff),
            .front_data (front_d),
            .rear_data  (rear_d),
            .chain_prev (prev_c),
            .data       (data_w[gi]),
            .chain_out  (chain_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ctl.compare   = 1'b0;
      ctl.scan      = 1'b0;
      ctl.apply     = 1'b0;
      ctl.act       = ACT_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_word.op;
               value_in = req_word.value;
               if (req_word.op == OP_PUSH || req_word.op == OP_POP) begin
                  state_in = ST_APPLY;
               end else begin
                  state_in = ST_COMPARE;
               end
            end
         end
         ST_COMPARE: begin
            ctl.compare = 1'b1;
            scan_in     = SW'(DEPTH - 2);
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (scan_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               scan_in = scan_ff - 1'b1;
            end
         end
         ST_APPLY: begin
            ctl.apply           = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.found        = 1'b0;
            rsp_in.popped_value = '0;
            case (op_ff)
               OP_PUSH: begin
                  if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     ctl.act  = ACT_PUSH;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_POP: begin
                  if (empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else begin
                     ctl.act             = ACT_POP;
                     rsp_in.popped_value = data_w[0];
                     count_in            = count_ff - 1'b1;
                  end
               end
               default: begin
                  if (empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else if (!found) begin
                     rsp_in.status = STATUS_NOTFOUND;
                  end else begin
                     rsp_in.found = 1'b1;
                     if (op_ff == OP_FIND) begin
                        ctl.act = ACT_FIND;
                     end else begin
                        ctl.act  = ACT_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
            endcase
            rsp_in.entry_count = ENTRY_W'(count_in);
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      scan_ff  <= scan_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   a_strobe_after_apply : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_APPLY))
      else $error("response strobe without list update");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.found |-> rsp_ff.status == STATUS_OK)
      else $error("found with failing status");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import mtf_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int CLOCK_PERIOD = 10;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   logic signed [DATA_W-1:0] list_model [0:LIST_DEPTH-1];
   int unsigned              list_count = 0;
   rsp_type                  expected_words [$];
   rsp_type                  expected_word;
   int                       mismatch_count = 0;
   int                       sender_idle_pct = 0;

   move_to_front_list_core #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void drop_entry(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < list_count; i++) begin
         list_model[i] = list_model[i + 1];
      end
      list_count--;
   endfunction

   function automatic void insert_front(logic signed [DATA_W-1:0] value);
      int unsigned i;
      for (i = list_count; i > 0; i--) begin
         list_model[i] = list_model[i - 1];
      end
      list_model[0] = value;
      list_count++;
   endfunction

   function automatic rsp_type apply_to_list(req_type word);
      rsp_type     result;
      int          hit;
      int unsigned i;
      result        = '0;
      result.status = STATUS_OK;
      hit           = -1;
      case (word.op)
         OP_PUSH: begin
            if (list_count >= LIST_DEPTH) result.status = STATUS_FULL;
            else insert_front(word.value);
         end
         OP_POP: begin
            if (list_count == 0) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.popped_value = list_model[0];
               drop_entry(0);
            end
         end
         default: begin
            if (list_count == 0) begin
               result.status = STATUS_EMPTY;
            end else begin
               for (i = 0; i < list_count && hit < 0; i++) begin
                  if (list_model[i] == word.value) hit = i;
               end
               if (hit < 0) begin
                  result.status = STATUS_NOTFOUND;
               end else begin
                  result.found = 1'b1;
                  drop_entry(hit);
                  if (word.op == OP_FIND) insert_front(word.value);
               end
            end
         end
      endcase
      result.entry_count = list_count[ENTRY_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_word));
         end else begin
            expected_word = expected_words[0];
            expected_words.delete(0);
            if (rsp_word.status !== expected_word.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_word.status, expected_word.status));
            if (rsp_word.found !== expected_word.found)
               report_mismatch($sformatf("found %b, want %b",
                                         rsp_word.found, expected_word.found));
            if (rsp_word.popped_value !== expected_word.popped_value)
               report_mismatch($sformatf("popped_value %h, want %h",
                                         rsp_word.popped_value,
                                         expected_word.popped_value));
            if (rsp_word.entry_count !== expected_word.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_word.entry_count,
                                         expected_word.entry_count));
         end
      end
   end

   task automatic send_word(op_type op, logic signed [DATA_W-1:0] value);
      req_type word;
      word.op    = op;
      word.value = value;
      start    <= 1'b1;
      req_word <= word;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      expected_words.push_back(apply_to_list(word));
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pool_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom_range(6) - 3;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] any_value();
      if ($urandom_range(99) < 55) return pool_value();
      return $urandom();
   endfunction

   function automatic logic signed [DATA_W-1:0] search_value();
      if (list_count > 0 && $urandom_range(99) < 60)
         return list_model[$urandom_range(list_count - 1)];
      return any_value();
   endfunction

   task automatic test_empty_list();
      send_word(OP_PUSH, 32'sh1234_5678);
      send_word(OP_POP, 32'shFFFF_FFFF);
      send_word(OP_POP, '0);
      send_word(OP_FIND, '0);
      send_word(OP_REMOVE, '0);
   endtask

   task automatic test_full_list();
      logic signed [DATA_W-1:0] fill [0:15] = '{
         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1,
         32'sd5, 32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA,
         32'sd1, 32'sd2, 32'sd3, -32'sd2,
         32'sh0000_FFFF, 32'shFFFF_0000, 32'sd100, -32'sd100
      };
      int k;
      for (k = 0; k < LIST_DEPTH; k++) begin
         send_word(OP_PUSH, fill[k % 16]);
      end
      send_word(OP_PUSH, 32'sd42);
   endtask

   task automatic test_search_duplicates();
      send_word(OP_FIND, 32'sd77);
      send_word(OP_FIND, 32'sh7FFF_FFFF);
      send_word(OP_REMOVE, 32'sd5);
      send_word(OP_FIND, 32'sd5);
   endtask

   task automatic test_random_traffic(int items, int idle_pct);
      int     k;
      int     push_pct;
      int     pick;
      op_type op;
      sender_idle_pct = idle_pct;
      push_pct        = 50;
      for (k = 0; k < items; k++) begin
         if (k % 64 == 0) push_pct = $urandom_range(75, 15);
         if (k % 150 == 149) wait_for_results();
         pick = $urandom_range(99);
         if (pick < push_pct) begin
            op = OP_PUSH;
         end else begin
            pick = $urandom_range(99);
            op   = pick < 40 ? OP_POP : (pick < 75 ? OP_FIND : OP_REMOVE);
         end
         case (op)
            OP_PUSH: send_word(op, any_value());
            OP_POP:  send_word(op, $urandom());
            default: send_word(op, search_value());
         endcase
      end
      wait_for_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_full_list();
      test_search_duplicates();
      wait_for_results();
      test_random_traffic(600, 12);
      test_random_traffic(600, 85);
      test_random_traffic(625, 0);
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("ERROR: run timed out");
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
hdl/mtf_pkg.sv
hdl/mtf_cell.sv
hdl/move_to_front_list_core.sv
bench/testbench.sv
